FILE: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants for the trial division prime test block: the width of the
// request field and the fixed values used in the candidate screen.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int CAND_BITS = 32;   // width of the candidate field on the request channel
  localparam int SMALLEST_PRIME = 2;
  localparam int FIRST_ODD_DIVISOR = 3;
  localparam int DIVISOR_STEP = 2;

endpackage

FILE: rtl/tdpt_in_if.sv
// ----------------------------------------------------------------------------
// tdpt_in_if
// Request channel: valid/ready handshake carrying one signed candidate.
// ----------------------------------------------------------------------------
interface tdpt_in_if
  import tdpt_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [CAND_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

FILE: rtl/tdpt_out_if.sv
// ----------------------------------------------------------------------------
// tdpt_out_if
// Result channel: valid/ready handshake carrying the one-bit prime flag.
// ----------------------------------------------------------------------------
interface tdpt_out_if
  import tdpt_pkg::*;
();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

FILE: rtl/tdpt_div.sv
// ----------------------------------------------------------------------------
// tdpt_div
// Bit-serial restoring divider. Retires one quotient bit per cycle while busy;
// done pulses once with the quotient and remainder valid.
// ----------------------------------------------------------------------------
module tdpt_div
  import tdpt_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);

  localparam int CW = $clog2(WIDTH + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;

  // Shift the next dividend bit into the partial remainder, then try a subtract.
  assign shifted = {rem, quot[WIDTH-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[WIDTH-2:0], ~diff[WIDTH]};
      // restore on borrow
      rem  <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether a signed candidate is prime by trial division.
// ----------------------------------------------------------------------------
// The candidate is read as a VALUE_BITS-wide two's complement number (bits
// above VALUE_BITS are dropped; above 32 bits it is always non-negative).
// Negative values, zero and one give is_prime = 0, two gives 1, other even
// values give 0; these answers go from the request straight to the finish
// state with no division. Odd values are divided by 3, 5, 7, ... in a
// bit-serial divider until a divisor exceeds the quotient (prime) or leaves
// no remainder (not prime). One request is worked on at a time; a new one
// is taken once the previous result has moved into the output register.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  tdpt_in_if.sink    request,
  tdpt_out_if.source result
);

  localparam int W = VALUE_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]   state;
  logic [W-1:0] value;
  logic [W-1:0] divisor;
  logic         start;
  logic         verdict;
  logic         out_valid;
  logic         out_prime;

  logic [W-1:0] cand_value;
  logic         cand_negative;
  logic         accept;
  logic         div_done;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;
  logic         out_free;
  logic         screened;
  logic         search_end;
  logic         start_next;
  logic         out_valid_next;

  generate
    if (W <= CAND_BITS) begin : g_narrow
      assign cand_value    = request.candidate[W-1:0];
      assign cand_negative = request.candidate[W-1];
    end else begin : g_wide
      assign cand_value    = {{(W - CAND_BITS){1'b0}}, request.candidate};
      assign cand_negative = 1'b0;
    end
  endgenerate

  assign request.ready   = (state == ST_IDLE);
  assign accept          = request.valid && request.ready;
  assign out_free        = !out_valid || result.ready;
  assign result.valid    = out_valid;
  assign result.is_prime = out_prime;

  // negative, zero, one and even values need no division
  assign screened   = cand_negative || cand_value[W-1:1] == '0 || !cand_value[0];
  assign search_end = divisor > div_quot || div_rem == '0;
  assign start_next = (accept && !screened) ||
                      (state == ST_DIVIDE && div_done && !search_end);
  assign out_valid_next = (state == ST_FINISH && out_free) ||
                          (out_valid && !result.ready);

  tdpt_div #(
    .WIDTH (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (value),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start     <= start_next;
      out_valid <= out_valid_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (screened) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done && search_end) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: candidate, trial divisor, verdict and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      value   <= cand_value;
      divisor <= W'(FIRST_ODD_DIVISOR);
      // screen: negative, zero, one and even values
      verdict <= !cand_negative && (cand_value == W'(SMALLEST_PRIME));
    end
    if (state == ST_DIVIDE && div_done) begin
      // divisor past the square root means no factor exists
      verdict <= divisor > div_quot;
      divisor <= divisor + W'(DIVISOR_STEP);
    end
    if (state == ST_FINISH && out_free) begin
      out_prime <= verdict;
    end
  end

endmodule
